// ----- hw/rtl/vepc_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex-edge proximity check package
// Shared widths, stage counts and beat types for the proximity check pipeline.
// ----------------------------------------------------------------------------
package vepc_pkg;

   // Field widths of the beats.
   localparam int COORD_W   = 32;
   localparam int ID_W      = 16;
   localparam int FRAC_BITS = 16;

   // Internal arithmetic widths.
   localparam int DIFF_W = COORD_W + 1;        // coordinate difference
   localparam int PROD_W = 2 * DIFF_W;         // product of two differences
   localparam int SUM_W  = PROD_W + 1;         // cross or dot product
   localparam int L2_W   = PROD_W;             // squared edge length
   localparam int ROOT_W = L2_W / 2;           // integer square root
   localparam int Q_W    = 32;                 // quotient width before saturation
   localparam int NUM_W  = SUM_W + FRAC_BITS;  // dividend width
   localparam int DEN_W  = L2_W;               // divisor width

   // Pipeline depths: three front stages, the square root, the distance
   // division and the output register.
   localparam int SQRT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = Q_W + 1;
   localparam int LATENCY     = 3 + SQRT_STAGES + DIV_STAGES + 1;

   localparam logic [COORD_W-1:0] UNIT_RESET = COORD_W'(65536);

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] finish_x;
      logic signed [COORD_W-1:0] finish_y;
      logic [ID_W-1:0]           point_id;
      logic [ID_W-1:0]           start_id;
      logic [ID_W-1:0]           finish_id;
      logic [ID_W-1:0]           edge_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]           out_point_id;
      logic [ID_W-1:0]           out_edge_id;
      logic                      conflict;
      logic [COORD_W-1:0]        distance;
      logic signed [COORD_W-1:0] ratio;
      logic                      degenerate;
   } rsp_type;

endpackage

// ----- hw/rtl/vepc_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// Square root pipeline
// Floor square root, one result bit per register stage, one beat per cycle.
// ----------------------------------------------------------------------------
module vepc_sqrt_pipe import vepc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [L2_W-1:0]   in_value,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root
);

   localparam int REM_W = ROOT_W + 4;

   logic              valid_ff [0:SQRT_STAGES-1];
   logic [REM_W-1:0]  rem_ff   [0:SQRT_STAGES-1];
   logic [ROOT_W-1:0] root_ff  [0:SQRT_STAGES-1];
   logic [L2_W-1:0]   value_ff [0:SQRT_STAGES-1];

   logic [REM_W-1:0]  cur_rem   [0:SQRT_STAGES-1];
   logic [ROOT_W-1:0] cur_root  [0:SQRT_STAGES-1];
   logic [L2_W-1:0]   cur_value [0:SQRT_STAGES-1];
   logic [REM_W-1:0]  rem_in    [0:SQRT_STAGES-1];
   logic [ROOT_W-1:0] root_in   [0:SQRT_STAGES-1];
   logic [REM_W-1:0]  shifted   [0:SQRT_STAGES-1];
   logic [REM_W-1:0]  trial     [0:SQRT_STAGES-1];
   logic              take      [0:SQRT_STAGES-1];

   // Each stage brings down two bits of the radicand and tries one root bit.
   always_comb begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            cur_rem[k]   = '0;
            cur_root[k]  = '0;
            cur_value[k] = in_value;
         end else begin
            cur_rem[k]   = rem_ff[k-1];
            cur_root[k]  = root_ff[k-1];
            cur_value[k] = value_ff[k-1];
         end
         shifted[k] = {cur_rem[k][REM_W-3:0], cur_value[k][L2_W-1:L2_W-2]};
         trial[k]   = {2'b00, cur_root[k], 2'b01};
         take[k]    = shifted[k] >= trial[k];
         rem_in[k]  = take[k] ? shifted[k] - trial[k] : shifted[k];
         root_in[k] = {cur_root[k][ROOT_W-2:0], take[k]};
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < SQRT_STAGES; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         rem_ff[k]   <= rem_in[k];
         root_ff[k]  <= root_in[k];
         value_ff[k] <= {cur_value[k][L2_W-3:0], 2'b00};
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];

endmodule

// ----- hw/rtl/vepc_div_pipe.sv -----
// ----------------------------------------------------------------------------
// Divider pipeline
// Restoring division giving a 32-bit quotient and an overflow flag, one
// quotient bit per register stage, one beat per cycle.
// ----------------------------------------------------------------------------
module vepc_div_pipe import vepc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quot,
   output logic             out_ovf
);

   logic             valid_ff [0:Q_W];
   logic [DEN_W-1:0] rem_ff   [0:Q_W];
   logic [Q_W-1:0]   low_ff   [0:Q_W];
   logic [DEN_W-1:0] den_ff   [0:Q_W];
   logic [Q_W-1:0]   quot_ff  [0:Q_W];
   logic             ovf_ff   [0:Q_W];

   logic [DEN_W:0]   trial  [1:Q_W];
   logic             take   [1:Q_W];
   logic [DEN_W-1:0] rem_in [1:Q_W];
   logic [DEN_W-1:0] head;

   // The upper part of the dividend must stay below the divisor, or the
   // quotient does not fit in its bits.
   assign head = DEN_W'(in_num[NUM_W-1:Q_W]);

   // One quotient bit per stage.
   always_comb begin
      for (int k = 1; k <= Q_W; k++) begin
         trial[k]  = {rem_ff[k-1], low_ff[k-1][Q_W-1]};
         take[k]   = trial[k] >= {1'b0, den_ff[k-1]};
         rem_in[k] = take[k] ? DEN_W'(trial[k] - {1'b0, den_ff[k-1]}) : DEN_W'(trial[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Q_W; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= Q_W; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= head;
      low_ff[0]  <= in_num[Q_W-1:0];
      den_ff[0]  <= in_den;
      quot_ff[0] <= '0;
      ovf_ff[0]  <= head >= in_den;
      for (int k = 1; k <= Q_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         low_ff[k]  <= {low_ff[k-1][Q_W-2:0], 1'b0};
         den_ff[k]  <= den_ff[k-1];
         quot_ff[k] <= {quot_ff[k-1][Q_W-2:0], take[k]};
         ovf_ff[k]  <= ovf_ff[k-1];
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quot  = quot_ff[Q_W];
   assign out_ovf   = ovf_ff[Q_W];

endmodule

// ----- hw/rtl/vertex_edge_proximity_check_top.sv -----
// ----------------------------------------------------------------------------
// Vertex-edge proximity check
// Distance, projection ratio and conflict flag for one vertex-edge pair.
// ----------------------------------------------------------------------------
// A pair is taken on every cycle that start is high; busy never rises. The
// result is shown with rsp_strobe for one cycle after passing three front
// stages, the 33-stage square root of the squared edge length, the 33-stage
// division of the cross product by that root and the output register; the
// ratio division runs alongside the square root. The receiver must take each
// result in the cycle it is shown. The unit edge length register is always
// ready and should be written only while no pair is in flight.
module vertex_edge_proximity_check_top import vepc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COORD_W-1:0] csr_data
);

   typedef struct packed {
      logic [ID_W-1:0]  pid;
      logic [ID_W-1:0]  eid;
      logic             id_ok;
      logic             in_range;
      logic             degen;
      logic             dneg;
      logic [SUM_W-1:0] cross_mag;
   } side_type;

   typedef struct packed {
      logic [ID_W-1:0] pid;
      logic [ID_W-1:0] eid;
      logic            id_ok;
      logic            in_range;
      logic            degen;
      logic            dneg;
      logic [Q_W-1:0]  ratio_q;
      logic            ratio_ovf;
   } ratio_side_type;

   // Configuration register.
   logic [COORD_W-1:0] unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unit_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // Stage 1: differences from the end point.
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_wx_ff, s1_wy_ff;
   logic [ID_W-1:0]          s1_pid_ff, s1_eid_ff;
   logic                     s1_id_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff    <= DIFF_W'(req_data.start_x) - DIFF_W'(req_data.finish_x);
      s1_dy_ff    <= DIFF_W'(req_data.start_y) - DIFF_W'(req_data.finish_y);
      s1_wx_ff    <= DIFF_W'(req_data.point_x) - DIFF_W'(req_data.finish_x);
      s1_wy_ff    <= DIFF_W'(req_data.point_y) - DIFF_W'(req_data.finish_y);
      s1_pid_ff   <= req_data.point_id;
      s1_eid_ff   <= req_data.edge_id;
      s1_id_ok_ff <= (req_data.point_id != req_data.start_id) &&
                     (req_data.point_id != req_data.finish_id);
   end

   // Stage 2: the six products.
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_dxdx_ff, s2_dydy_ff, s2_dxwy_ff;
   logic signed [PROD_W-1:0] s2_dywx_ff, s2_dxwx_ff, s2_dywy_ff;
   logic [ID_W-1:0]          s2_pid_ff, s2_eid_ff;
   logic                     s2_id_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_dxdx_ff  <= s1_dx_ff * s1_dx_ff;
      s2_dydy_ff  <= s1_dy_ff * s1_dy_ff;
      s2_dxwy_ff  <= s1_dx_ff * s1_wy_ff;
      s2_dywx_ff  <= s1_dy_ff * s1_wx_ff;
      s2_dxwx_ff  <= s1_dx_ff * s1_wx_ff;
      s2_dywy_ff  <= s1_dy_ff * s1_wy_ff;
      s2_pid_ff   <= s1_pid_ff;
      s2_eid_ff   <= s1_eid_ff;
      s2_id_ok_ff <= s1_id_ok_ff;
   end

   // Stage 3: cross, dot and squared length, with magnitudes.
   logic signed [SUM_W-1:0] cross_s, dot_s;
   logic                    s3_valid_ff;
   logic [L2_W-1:0]         s3_l2_ff;
   logic [SUM_W-1:0]        s3_cross_ff, s3_dot_ff;
   logic                    s3_dneg_ff;
   logic [ID_W-1:0]         s3_pid_ff, s3_eid_ff;
   logic                    s3_id_ok_ff;

   assign cross_s = SUM_W'(s2_dxwy_ff) - SUM_W'(s2_dywx_ff);
   assign dot_s   = SUM_W'(s2_dxwx_ff) + SUM_W'(s2_dywy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_l2_ff    <= L2_W'(s2_dxdx_ff) + L2_W'(s2_dydy_ff);
      s3_cross_ff <= cross_s[SUM_W-1] ? -cross_s : cross_s;
      s3_dot_ff   <= dot_s[SUM_W-1] ? -dot_s : dot_s;
      s3_dneg_ff  <= dot_s[SUM_W-1];
      s3_pid_ff   <= s2_pid_ff;
      s3_eid_ff   <= s2_eid_ff;
      s3_id_ok_ff <= s2_id_ok_ff;
   end

   // Square root of the squared length and the ratio division run side by side.
   logic              sq_valid, ra_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [Q_W-1:0]    ra_quot;
   logic              ra_ovf;

   vepc_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_value  (s3_l2_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root)
   );

   vepc_div_pipe u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    ({s3_dot_ff, FRAC_BITS'(0)}),
      .in_den    (s3_l2_ff),
      .out_valid (ra_valid),
      .out_quot  (ra_quot),
      .out_ovf   (ra_ovf)
   );

   // Side data follows the square root.
   side_type side_entry;
   side_type side_a_ff [0:SQRT_STAGES-1];

   always_comb begin
      side_entry.pid       = s3_pid_ff;
      side_entry.eid       = s3_eid_ff;
      side_entry.id_ok     = s3_id_ok_ff;
      side_entry.in_range  = !s3_dneg_ff && (s3_dot_ff <= SUM_W'(s3_l2_ff));
      side_entry.degen     = s3_l2_ff == '0;
      side_entry.dneg      = s3_dneg_ff;
      side_entry.cross_mag = s3_cross_ff;
   end

   always_ff @(posedge clock) begin
      side_a_ff[0] <= side_entry;
      for (int k = 1; k < SQRT_STAGES; k++) side_a_ff[k] <= side_a_ff[k-1];
   end

   // Distance division by the edge length.
   side_type       side_a_tail;
   ratio_side_type side_b_entry;
   ratio_side_type side_b_ff [0:DIV_STAGES-1];
   logic           di_valid;
   logic [Q_W-1:0] di_quot;
   logic           di_ovf;

   assign side_a_tail = side_a_ff[SQRT_STAGES-1];

   vepc_div_pipe u_dist_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid && ra_valid),
      .in_num    (NUM_W'(side_a_tail.cross_mag)),
      .in_den    (DEN_W'(sq_root)),
      .out_valid (di_valid),
      .out_quot  (di_quot),
      .out_ovf   (di_ovf)
   );

   always_comb begin
      side_b_entry.pid       = side_a_tail.pid;
      side_b_entry.eid       = side_a_tail.eid;
      side_b_entry.id_ok     = side_a_tail.id_ok;
      side_b_entry.in_range  = side_a_tail.in_range;
      side_b_entry.degen     = side_a_tail.degen;
      side_b_entry.dneg      = side_a_tail.dneg;
      side_b_entry.ratio_q   = ra_quot;
      side_b_entry.ratio_ovf = ra_ovf;
   end

   always_ff @(posedge clock) begin
      side_b_ff[0] <= side_b_entry;
      for (int k = 1; k < DIV_STAGES; k++) side_b_ff[k] <= side_b_ff[k-1];
   end

   // Saturation and the conflict test.
   localparam logic [Q_W-1:0] NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [Q_W-1:0] POS_LIMIT = {1'b0, {(Q_W-1){1'b1}}};

   ratio_side_type side_b_tail;
   logic [Q_W-1:0] dist_sat, ratio_sat;
   logic           close;
   logic           rsp_strobe_ff;
   rsp_type        rsp_ff;

   assign side_b_tail = side_b_ff[DIV_STAGES-1];

   always_comb begin
      dist_sat = di_ovf ? '1 : di_quot;
      if (side_b_tail.dneg) begin
         if (side_b_tail.ratio_ovf || side_b_tail.ratio_q > NEG_LIMIT) begin
            ratio_sat = NEG_LIMIT;
         end else begin
            ratio_sat = -side_b_tail.ratio_q;
         end
      end else begin
         if (side_b_tail.ratio_ovf || side_b_tail.ratio_q > POS_LIMIT) begin
            ratio_sat = POS_LIMIT;
         end else begin
            ratio_sat = side_b_tail.ratio_q;
         end
      end
      close = {dist_sat, 1'b0} < {1'b0, unit_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= di_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.out_point_id <= side_b_tail.pid;
      rsp_ff.out_edge_id  <= side_b_tail.eid;
      rsp_ff.degenerate   <= side_b_tail.degen;
      rsp_ff.distance     <= side_b_tail.degen ? '0 : dist_sat;
      rsp_ff.ratio        <= side_b_tail.degen ? '0 : ratio_sat;
      rsp_ff.conflict     <= !side_b_tail.degen && side_b_tail.id_ok &&
                             side_b_tail.in_range && close;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // The two parallel units must stay in step.
   a_units_aligned: assert property (@(posedge clock) disable iff (reset)
      sq_valid == ra_valid)
      else $error("square root and ratio divider out of step");

   // Every accepted pair gives a result strobe once it has passed the whole pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result missing after pipeline latency");

   // A zero-length edge gives zero fields and no conflict.
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.degenerate) |->
         (!rsp_data.conflict && rsp_data.distance == '0 && rsp_data.ratio == '0))
      else $error("degenerate edge gave nonzero result");

   // A conflict needs a ratio that is not negative.
   a_conflict_ratio: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.conflict) |-> !rsp_data.ratio[COORD_W-1])
      else $error("conflict with negative ratio");

endmodule
